/* design/s3x_pkg.sv */
package s3x_pkg;

  // Geometry of the line stores and the frame.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W    = COL_W + 1;
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // One input request.
  typedef struct packed {
    cmd_e cmd;
    pix_t pixel_in;
  } in_item_t;

  // One output block.
  typedef struct packed {
    pix_t             top_left;
    pix_t             top_mid;
    pix_t             top_right;
    pix_t             mid_left;
    pix_t             centre;
    pix_t             mid_right;
    pix_t             bottom_left;
    pix_t             bottom_mid;
    pix_t             bottom_right;
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic             last_in_run;
  } out_item_t;

  // Neighborhood A B C / D E F / G H I.
  typedef struct packed {
    pix_t a;
    pix_t b;
    pix_t c;
    pix_t d;
    pix_t e;
    pix_t f;
    pix_t g;
    pix_t h;
    pix_t i;
  } window_t;

  // Blocks that one accepted request hands to the output side.
  typedef struct packed {
    logic             first;
    logic             second;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } job_t;

endpackage

/* design/s3x_ram.sv */
module s3x_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; a read of the address
  // being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/s3x_front.sv */
module s3x_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [s3x_pkg::WIDTH_W-1:0]   cfg_wdata_i,
  input  logic                          accept_i,
  input  s3x_pkg::in_item_t             item_i,
  output s3x_pkg::window_t              window_o,
  output s3x_pkg::job_t                 start_o
);
  import s3x_pkg::*;

  logic [WIDTH_W-1:0] line_width_q;
  logic [WIDTH_W-1:0] w_eff;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               last_col, flush, row_zero, active;
  logic               mid_we, up_we;
  pix_t               mid_rdata, up_rdata;
  pix_t               mid_px, up_px, low_px;
  logic               mid_fwd_q, mid_fwd_d, up_fwd_q, up_fwd_d;
  pix_t               mid_fwd_data_q, up_fwd_data_q;
  window_t            window_q, window_d;

  // Line width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WIDTH_W'(MAX_WIDTH);
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  // Line stores, read one column ahead so the data waits at the RAM output.
  s3x_ram #(.Width(PIX_W), .Depth(MAX_WIDTH)) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (mid_we),
    .waddr_i (col_q),
    .wdata_i (low_px),
    .raddr_i (col_d),
    .rdata_o (mid_rdata)
  );

  s3x_ram #(.Width(PIX_W), .Depth(MAX_WIDTH)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (col_q),
    .wdata_i (mid_px),
    .raddr_i (col_d),
    .rdata_o (up_rdata)
  );

  // Column and row bookkeeping, store access and window update.
  always_comb begin
    if (line_width_q == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (line_width_q > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width_q;
    end
    last_col = ({1'b0, col_q} >= (w_eff - WIDTH_W'(1)));
    flush    = (item_i.cmd == CMD_FLUSH);
    row_zero = (row_q == '0);
    // A flush before any row has been stored does nothing.
    active   = accept_i && !(flush && row_zero);

    mid_px = mid_fwd_q ? mid_fwd_data_q : mid_rdata;
    if (row_q == ROW_W'(1)) begin
      up_px = mid_px;
    end else begin
      up_px = up_fwd_q ? up_fwd_data_q : up_rdata;
    end
    // A flush stands for a copy of the row above.
    low_px = flush ? mid_px : item_i.pixel_in;

    mid_we = active;
    up_we  = active && !row_zero;

    col_d = col_q;
    row_d = row_q;
    if (active) begin
      if (last_col) begin
        col_d = '0;
        if (flush) begin
          row_d = '0;
        end else if (row_q < ROW_W'(MAX_HEIGHT - 1)) begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end

    // Store data written now and read back next cycle is taken from here.
    mid_fwd_d = mid_we && (col_q == col_d);
    up_fwd_d  = up_we && (col_q == col_d);

    window_d = window_q;
    if (up_we) begin
      if (col_q == '0) begin
        window_d.a = up_px;
        window_d.b = up_px;
        window_d.c = up_px;
        window_d.d = mid_px;
        window_d.e = mid_px;
        window_d.f = mid_px;
        window_d.g = low_px;
        window_d.h = low_px;
        window_d.i = low_px;
      end else begin
        window_d.a = window_q.b;
        window_d.b = window_q.c;
        window_d.c = up_px;
        window_d.d = window_q.e;
        window_d.e = window_q.f;
        window_d.f = mid_px;
        window_d.g = window_q.h;
        window_d.h = window_q.i;
        window_d.i = low_px;
      end
    end

    start_o.first  = up_we && (col_q != '0);
    start_o.second = up_we && last_col;
    start_o.col    = col_q;
    start_o.row    = row_q - ROW_W'(1);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      mid_fwd_q <= 1'b0;
      up_fwd_q  <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      mid_fwd_q <= mid_fwd_d;
      up_fwd_q  <= up_fwd_d;
    end
  end

  // Window and forwarded store data.
  always_ff @(posedge clk_i) begin
    window_q       <= window_d;
    mid_fwd_data_q <= low_px;
    up_fwd_data_q  <= mid_px;
  end

  assign window_o = window_q;

endmodule

/* design/s3x_back.sv */
module s3x_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  s3x_pkg::job_t       start_i,
  input  s3x_pkg::window_t    window_i,
  output logic                can_take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output s3x_pkg::out_item_t  out_data_o
);
  import s3x_pkg::*;

  logic             pend_first_q, pend_first_d;
  logic             pend_second_q, pend_second_d;
  logic [COL_W-1:0] job_col_q;
  logic [ROW_W-1:0] job_row_q;
  logic             busy, out_free, emit, use_second;
  logic             out_valid_q, out_valid_d;
  window_t          view;
  out_item_t        block, out_q;

  // Scale3x corner, edge and center rules.
  function automatic out_item_t scale3x(window_t w);
    logic      db, bf, hd, fh;
    out_item_t o;
    db = (w.d == w.b) && (w.d != w.h) && (w.b != w.f);
    bf = (w.b == w.f) && (w.b != w.d) && (w.f != w.h);
    hd = (w.h == w.d) && (w.h != w.f) && (w.d != w.b);
    fh = (w.f == w.h) && (w.f != w.b) && (w.h != w.d);
    o              = '0;
    o.top_left     = db ? w.d : w.e;
    o.top_mid      = ((db && w.e != w.c) || (bf && w.e != w.a)) ? w.b : w.e;
    o.top_right    = bf ? w.f : w.e;
    o.mid_left     = ((hd && w.e != w.a) || (db && w.e != w.g)) ? w.d : w.e;
    o.centre       = w.e;
    o.mid_right    = ((bf && w.e != w.i) || (fh && w.e != w.c)) ? w.f : w.e;
    o.bottom_left  = hd ? w.d : w.e;
    o.bottom_mid   = ((fh && w.e != w.g) || (hd && w.e != w.i)) ? w.h : w.e;
    o.bottom_right = fh ? w.f : w.e;
    return o;
  endfunction

  // Job slot and handshake control.
  always_comb begin
    busy       = pend_first_q || pend_second_q;
    out_free   = !out_valid_q || out_ready_i;
    emit       = out_free && busy;
    use_second = !pend_first_q;
    can_take_o = !busy || (out_free && !(pend_first_q && pend_second_q));

    pend_first_d  = pend_first_q;
    pend_second_d = pend_second_q;
    if (emit) begin
      if (pend_first_q) begin
        pend_first_d = 1'b0;
      end else begin
        pend_second_d = 1'b0;
      end
    end
    if (accept_i) begin
      pend_first_d  = start_i.first;
      pend_second_d = start_i.second;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // The row-end block sees the window moved one more column, right edge repeated.
  always_comb begin
    view = window_i;
    if (use_second) begin
      view.a = window_i.b;
      view.b = window_i.c;
      view.d = window_i.e;
      view.e = window_i.f;
      view.g = window_i.h;
      view.h = window_i.i;
    end
    block         = scale3x(view);
    block.src_row = job_row_q;
    if (use_second) begin
      block.src_col     = job_col_q;
      block.last_in_run = 1'b1;
    end else begin
      block.src_col     = job_col_q - COL_W'(1);
      block.last_in_run = !pend_second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_first_q  <= 1'b0;
      pend_second_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pend_first_q  <= pend_first_d;
      pend_second_q <= pend_second_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Job position and output register.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_col_q <= start_i.col;
      job_row_q <= start_i.row;
    end
    if (emit) begin
      out_q <= block;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A pending block to the left of the current column needs a column to its left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_first_q |-> (job_col_q != '0))
    else $error("first block pending at column zero");

  // The row-end block always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !pend_first_q) |=> (out_valid_q && out_q.last_in_run))
    else $error("row-end block without last_in_run");

  // A block followed by a row-end block does not close its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && pend_first_q && pend_second_q) |=> (out_valid_q && !out_q.last_in_run))
    else $error("first of two blocks marked last");

endmodule

/* design/pixel_art_upscale_3x.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i   (in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o  (out_item_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (line width)
//
// One request is taken per clock unless blocks are pending and the output stalls.
// A request that ends a source row produces two blocks, so in_ready_o stays low until
// the first of them goes out. The first block of a request passes through the window
// register and then the output register; the stores, being read ahead, add no register.
// Reset clears the counters, the pending blocks and out_valid_o, not the line stores.
// A stalled output holds its block while one more request still fits the job slot.
module pixel_art_upscale_3x (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [s3x_pkg::WIDTH_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  s3x_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output s3x_pkg::out_item_t          out_data_o
);
  import s3x_pkg::*;

  logic    accept;
  logic    can_take;
  window_t window;
  job_t    start;

  assign in_ready_o = can_take;
  assign accept     = in_valid_i && can_take;

  // Line stores, counters and the 3x3 window.
  s3x_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .window_o    (window),
    .start_o     (start)
  );

  // Block rules and output register.
  s3x_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_i     (start),
    .window_i    (window),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
